/* src/sha256_pkg.sv */
`default_nettype none
package sha256_pkg;

	typedef logic [31:0] word_t;

	// Controller to datapath commands
	typedef struct packed {
		logic       clear;      // return chain and counter to initial values
		logic       put_byte;   // store byte at current fill position
		logic       pad_begin;  // write 0x80 at fill, zeros after it
		logic       zero_block; // clear whole block (length-only block)
		logic       put_len;    // write bit length into bytes 56..63
		logic       load;       // load schedule and working words
		logic       round;      // run one round
		logic       fold;       // add working words into chain
		logic [2:0] out_sel;    // digest word select
	} dp_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic       block_full; // fill at 63, next byte completes the block
		logic       pad_two;    // fill above 55
		logic       last_round; // round counter at 63
	} dp_sts_t;

	localparam logic [7:0] PadByte = 8'h80;
	localparam logic [5:0] PadLimit = 6'd55;

	localparam word_t InitH [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam word_t RoundK [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic word_t ror(input word_t v, input int unsigned r);
		ror = (v >> r) | (v << (32 - r));
	endfunction

endpackage
`default_nettype wire

/* src/sha256_if.sv */
`default_nettype none
interface sha256_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       has_byte;
	logic       end_of_message;
	modport source (output valid, data_byte, has_byte, end_of_message, input ready);
	modport sink (input valid, data_byte, has_byte, end_of_message, output ready);
endinterface

interface sha256_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;
	modport source (output valid, digest_word, word_index, last_word, input ready);
	modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface
`default_nettype wire

/* src/sha256_dp.sv */
`default_nettype none
module sha256_dp (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire sha256_pkg::dp_cmd_t cmd,
	input  wire logic [7:0]          data_byte,
	output sha256_pkg::dp_sts_t      sts,
	output sha256_pkg::word_t        digest_word
);
	sha256_pkg::word_t chain_q [8];
	sha256_pkg::word_t work_q [8];
	sha256_pkg::word_t sched_q [16];
	sha256_pkg::word_t blk_q [16];  // message block, big-endian words
	logic [63:0] count_q;
	logic [5:0]  round_q;

	logic [5:0]  fill;
	logic [63:0] bits;
	sha256_pkg::word_t w15, w2, wnew, w, s0, s1, ch, maj, t1, t2, a, e;

	assign fill = count_q[5:0];
	assign bits = {count_q[60:0], 3'b000};

	// Schedule word for this round: first 16 straight, then expanded
	always_comb begin
		w15 = sched_q[1];
		w2 = sched_q[14];
		wnew = sched_q[0] + sched_q[9]
			+ (sha256_pkg::ror(w15, 7) ^ sha256_pkg::ror(w15, 18) ^ (w15 >> 3))
			+ (sha256_pkg::ror(w2, 17) ^ sha256_pkg::ror(w2, 19) ^ (w2 >> 10));
		w = (round_q < 6'd16) ? sched_q[round_q[3:0]] : wnew;
	end

	// Round function
	always_comb begin
		a = work_q[0];
		e = work_q[4];
		s1 = sha256_pkg::ror(e, 6) ^ sha256_pkg::ror(e, 11) ^ sha256_pkg::ror(e, 25);
		ch = (e & work_q[5]) ^ (~e & work_q[6]);
		t1 = work_q[7] + s1 + ch + sha256_pkg::RoundK[round_q] + w;
		s0 = sha256_pkg::ror(a, 2) ^ sha256_pkg::ror(a, 13) ^ sha256_pkg::ror(a, 22);
		maj = (a & work_q[1]) ^ (a & work_q[2]) ^ (work_q[1] & work_q[2]);
		t2 = s0 + maj;
	end

	assign sts.block_full = fill == 6'd63;
	assign sts.pad_two = fill > sha256_pkg::PadLimit;
	assign sts.last_round = round_q == 6'd63;
	assign digest_word = chain_q[cmd.out_sel];

	// Chain words and byte counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) chain_q[i] <= sha256_pkg::InitH[i];
			count_q <= '0;
		end else if (cmd.clear) begin
			for (int i = 0; i < 8; i++) chain_q[i] <= sha256_pkg::InitH[i];
			count_q <= '0;
		end else begin
			if (cmd.fold)
				for (int i = 0; i < 8; i++) chain_q[i] <= chain_q[i] + work_q[i];
			if (cmd.put_byte) count_q <= count_q + 64'd1;
		end
	end

	// Block buffer, byte lanes big-endian within each word
	always_ff @(posedge clk) begin
		if (cmd.put_byte) blk_q[fill[5:2]][{~fill[1:0], 3'b000} +: 8] <= data_byte;
		if (cmd.pad_begin)
			for (int i = 0; i < 64; i++)
				if (6'(i) == fill) blk_q[i/4][8*(3 - i%4) +: 8] <= sha256_pkg::PadByte;
				else if (6'(i) > fill) blk_q[i/4][8*(3 - i%4) +: 8] <= 8'h00;
		if (cmd.zero_block)
			for (int i = 0; i < 16; i++) blk_q[i] <= '0;
		if (cmd.put_len) begin
			blk_q[14] <= bits[63:32];
			blk_q[15] <= bits[31:0];
		end
	end

	// Schedule window, working words and round counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			round_q <= '0;
		end else if (cmd.load) begin
			round_q <= '0;
		end else if (cmd.round) begin
			round_q <= round_q + 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			for (int j = 0; j < 16; j++) sched_q[j] <= blk_q[j];
			for (int i = 0; i < 8; i++) work_q[i] <= chain_q[i];
		end else if (cmd.round) begin
			// window slides once expanded words are in use
			if (round_q >= 6'd16) begin
				for (int j = 0; j < 15; j++) sched_q[j] <= sched_q[j+1];
				sched_q[15] <= wnew;
			end
			work_q[7] <= work_q[6];
			work_q[6] <= work_q[5];
			work_q[5] <= work_q[4];
			work_q[4] <= work_q[3] + t1;
			work_q[3] <= work_q[2];
			work_q[2] <= work_q[1];
			work_q[1] <= work_q[0];
			work_q[0] <= t1 + t2;
		end
	end
endmodule
`default_nettype wire

/* src/sha256_ctrl.sv */
`default_nettype none
module sha256_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	input  wire logic                has_byte,
	input  wire logic                end_of_message,
	output logic                     in_ready,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic [2:0]               word_index,
	output logic                     last_word,
	input  wire sha256_pkg::dp_sts_t sts,
	output sha256_pkg::dp_cmd_t      cmd
);
	localparam logic [2:0] StIdle = 3'd0;
	localparam logic [2:0] StLoad = 3'd1;
	localparam logic [2:0] StRound = 3'd2;
	localparam logic [2:0] StFold = 3'd3;
	localparam logic [2:0] StPad = 3'd4;
	localparam logic [2:0] StLen = 3'd5;
	localparam logic [2:0] StOut = 3'd6;

	logic [2:0] state_q, state_d;
	logic       fin_q, fin_d;   // final block of a message in flight
	logic       pend_q, pend_d; // padding or length-only block still to come
	logic [2:0] idx_q, idx_d;
	logic       take;

	assign in_ready = state_q == StIdle;
	assign take = in_valid && in_ready;
	assign out_valid = state_q == StOut;
	assign word_index = idx_q;
	assign last_word = idx_q == 3'd7;

	always_comb begin
		state_d = state_q;
		fin_d = fin_q;
		pend_d = pend_q;
		idx_d = idx_q;
		cmd = '0;
		cmd.out_sel = idx_q;
		case (state_q)
			StIdle: begin
				if (take) begin
					cmd.put_byte = has_byte;
					if (has_byte && sts.block_full) begin
						state_d = StLoad;
						fin_d = 1'b0;
						pend_d = end_of_message;
					end else if (end_of_message) begin
						state_d = StPad;
					end
				end
			end
			StPad: begin
				cmd.pad_begin = 1'b1;
				if (sts.pad_two) begin
					state_d = StLoad;
					fin_d = 1'b0;
					pend_d = 1'b1;
				end else begin
					state_d = StLen;
				end
			end
			StLen: begin
				cmd.put_len = 1'b1;
				state_d = StLoad;
				fin_d = 1'b1;
				pend_d = 1'b0;
			end
			StLoad: begin
				cmd.load = 1'b1;
				state_d = StRound;
			end
			StRound: begin
				cmd.round = 1'b1;
				if (sts.last_round) state_d = StFold;
			end
			StFold: begin
				cmd.fold = 1'b1;
				if (fin_q) begin
					state_d = StOut;
					idx_d = 3'd0;
				end else if (pend_q) begin
					// after a full block: pad fresh block, or zero block then length
					state_d = sts.pad_two ? StLen : StPad;
					pend_d = 1'b0;
				end else begin
					state_d = StIdle;
				end
			end
			StOut: begin
				if (out_ready) begin
					idx_d = idx_q + 3'd1;
					if (idx_q == 3'd7) begin
						cmd.clear = 1'b1;
						state_d = StIdle;
					end
				end
			end
			default: state_d = StIdle;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= StIdle;
			fin_q <= 1'b0;
			pend_q <= 1'b0;
			idx_q <= '0;
		end else begin
			state_q <= state_d;
			fin_q <= fin_d;
			pend_q <= pend_d;
			idx_q <= idx_d;
		end
	end
endmodule
`default_nettype wire

/* src/sha256_zblk.sv */
`default_nettype none
// Length-only block staging: after a pad that overflowed, clear and write length
module sha256_zblk (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire sha256_pkg::dp_cmd_t cmd_in,
	output sha256_pkg::dp_cmd_t      cmd_out
);
	logic pad_two_q;

	// set by a fold after the last pad, so at a length write it marks a two-block tail
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) pad_two_q <= 1'b0;
		else if (cmd_in.pad_begin) pad_two_q <= 1'b0;
		else if (cmd_in.fold) pad_two_q <= 1'b1;
		else if (cmd_in.put_len || cmd_in.clear) pad_two_q <= 1'b0;
	end

	always_comb begin
		cmd_out = cmd_in;
		cmd_out.zero_block = cmd_in.put_len && pad_two_q;
	end
endmodule
`default_nettype wire

/* src/sha_256_hash.sv */
`default_nettype none
// SHA-256 streaming hasher, at most one byte per request.
// Byte requests are taken while idle; the 64th byte of a block stalls input through
// the load, 64 rounds of the single round unit and the fold.
// End of message: padding and length writes plus one or two compressions,
// then eight digest words. Reset (arst_n low) restores the initial hash values.
module sha_256_hash (
	input  wire logic   clk,
	input  wire logic   arst_n,
	sha256_in_if.sink   in_ch,
	sha256_out_if.source out_ch
);
	sha256_pkg::dp_cmd_t cmd_raw, cmd;
	sha256_pkg::dp_sts_t sts;

	sha256_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_ch.valid), .has_byte(in_ch.has_byte),
		.end_of_message(in_ch.end_of_message), .in_ready(in_ch.ready),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.word_index(out_ch.word_index), .last_word(out_ch.last_word),
		.sts(sts), .cmd(cmd_raw)
	);

	sha256_zblk u_zblk (.clk(clk), .arst_n(arst_n), .cmd_in(cmd_raw), .cmd_out(cmd));

	sha256_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .data_byte(in_ch.data_byte),
		.sts(sts), .digest_word(out_ch.digest_word)
	);
endmodule
`default_nettype wire

/* verif/sha_256_hash_test.sv */
`default_nettype none
module sha_256_hash_test;

	// Scoreboard: SHA-256 predictor and queue of pending digest words
	class digest_board;
		sha256_pkg::word_t chain [8];
		logic [7:0] blk [64];
		logic [63:0] nbytes;
		sha256_pkg::word_t digest_q [$];
		int errors;

		function new();
			errors = 0;
			restart();
		endfunction

		function void restart();
			for (int i = 0; i < 8; i++) chain[i] = sha256_pkg::InitH[i];
			for (int i = 0; i < 64; i++) blk[i] = 8'h00;
			nbytes = '0;
		endfunction

		function sha256_pkg::word_t rr(sha256_pkg::word_t v, int r);
			return (v >> r) | (v << (32 - r));
		endfunction

		function void compress();
			sha256_pkg::word_t w [16];
			sha256_pkg::word_t v [8];
			sha256_pkg::word_t s0, s1, t1, t2, ch, mj;
			for (int j = 0; j < 16; j++)
				w[j] = {blk[4*j], blk[4*j+1], blk[4*j+2], blk[4*j+3]};
			for (int j = 0; j < 8; j++) v[j] = chain[j];
			for (int t = 0; t < 64; t++) begin
				if (t >= 16) begin
					s0 = rr(w[(t-15)&15], 7) ^ rr(w[(t-15)&15], 18) ^ (w[(t-15)&15] >> 3);
					s1 = rr(w[(t-2)&15], 17) ^ rr(w[(t-2)&15], 19) ^ (w[(t-2)&15] >> 10);
					w[t&15] = w[t&15] + s0 + w[(t-7)&15] + s1;
				end
				s1 = rr(v[4], 6) ^ rr(v[4], 11) ^ rr(v[4], 25);
				ch = (v[4] & v[5]) ^ (~v[4] & v[6]);
				t1 = v[7] + s1 + ch + sha256_pkg::RoundK[t] + w[t&15];
				s0 = rr(v[0], 2) ^ rr(v[0], 13) ^ rr(v[0], 22);
				mj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
				t2 = s0 + mj;
				v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
				v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
			end
			for (int j = 0; j < 8; j++) chain[j] += v[j];
		endfunction

		// note one accepted request
		function void note_request(logic [7:0] b, logic has, logic eom);
			int fill;
			logic [63:0] bits;
			if (has) begin
				blk[nbytes[5:0]] = b;
				nbytes++;
				if (nbytes[5:0] == 0) compress();
			end
			if (!eom) return;
			fill = nbytes[5:0];
			blk[fill] = sha256_pkg::PadByte;
			for (int j = fill + 1; j < 64; j++) blk[j] = 8'h00;
			if (fill > sha256_pkg::PadLimit) begin
				compress();
				for (int j = 0; j < 64; j++) blk[j] = 8'h00;
			end
			bits = nbytes << 3;
			for (int j = 0; j < 8; j++) blk[63-j] = bits[8*j +: 8];
			compress();
			for (int j = 0; j < 8; j++) digest_q.push_back(chain[j]);
			restart();
		endfunction

		// check one digest word, its index and last flag against the oldest expectation
		function void check_word(sha256_pkg::word_t d, logic [2:0] idx, logic lw);
			sha256_pkg::word_t e;
			logic [2:0] ei;
			if (digest_q.size() == 0) begin
				$error("unexpected digest word %h", d);
				errors++;
				return;
			end
			ei = 3'(7 - ((digest_q.size() - 1) % 8));
			e = digest_q.pop_front();
			if (d !== e) begin
				$error("digest_word expected %h actual %h", e, d);
				errors++;
			end
			if (idx !== ei) begin
				$error("word_index expected %0d actual %0d", ei, idx);
				errors++;
			end
			if (lw !== (ei == 3'd7)) begin
				$error("last_word expected %0d actual %0d", ei == 3'd7, lw);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	sha256_in_if in_ch ();
	sha256_out_if out_ch ();
	digest_board board;
	bit quiet_end = 0;
	bit hold_off = 0;
	int idle_cycles = 0;

	sha_256_hash dut (.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch));

	always #5 clk = ~clk;

	initial begin
		in_ch.valid = 1'b0;
		in_ch.data_byte = 8'h00;
		in_ch.has_byte = 1'b0;
		in_ch.end_of_message = 1'b0;
		out_ch.ready = 1'b0;
		board = new();
	end

	// monitor: note requests, check results, watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (in_ch.valid && in_ch.ready)
				board.note_request(in_ch.data_byte, in_ch.has_byte, in_ch.end_of_message);
			if (out_ch.valid && out_ch.ready)
				board.check_word(out_ch.digest_word, out_ch.word_index, out_ch.last_word);
			if (idle_cycles > 5000) begin
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	// receiver: random stall bursts, one long hold-off
	always @(posedge clk) begin
		if (hold_off || (!quiet_end && $urandom_range(0, 4) == 0)) begin
			out_ch.ready <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end else begin
			out_ch.ready <= 1'b1;
		end
	end

	// send one request and wait for acceptance
	task automatic send(logic [7:0] b, logic has, logic eom);
		if (!quiet_end && $urandom_range(0, 5) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data_byte <= b;
		in_ch.has_byte <= has;
		in_ch.end_of_message <= eom;
		do @(posedge clk); while (!in_ch.ready);
	endtask

	task automatic send_message(int len, bit mixed);
		for (int i = 0; i < len; i++) begin
			// occasional empty request in mixed messages
			if (mixed && $urandom_range(0, 7) == 0) send(8'($urandom), 1'b0, 1'b0);
			send(8'($urandom), 1'b1, (i == len - 1) && mixed && $urandom_range(0, 1));
			if ((i == len - 1) && in_ch.end_of_message) return;
		end
		send(8'($urandom), 1'b0, 1'b1);
	endtask

	task automatic drain();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (board.digest_q.size() != 0) @(posedge clk);
	endtask

	initial begin
		int sent;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty message, byte extremes, end with byte, pad boundaries
		send(8'h00, 1'b0, 1'b1);
		send(8'hff, 1'b1, 1'b1);
		send(8'h00, 1'b1, 1'b0);
		send(8'h5a, 1'b0, 1'b0);
		send(8'ha5, 1'b1, 1'b1);
		drain();
		send_message(55, 0);
		send_message(56, 0);
		drain();

		// receiver holds off while the sender keeps offering
		fork
			begin
				hold_off = 1;
				repeat (400) @(posedge clk);
				hold_off = 0;
			end
			begin
				send_message(3, 0);
				send_message(2, 0);
			end
		join
		send_message(1, 1);
		drain();

		// random messages, mostly short, a few spanning blocks
		sent = 0;
		while (sent < 230) begin
			int len;
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 130) : $urandom_range(0, 12);
			if (sent > 190) quiet_end = 1;
			send_message(len, 1);
			sent += len + 1;
		end
		drain();
		repeat (300) @(posedge clk);
		if (board.errors == 0 && board.digest_q.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule
`default_nettype wire
